FILE: rtl/core/ssmf_pkg.sv
// shared types and constants for the sorted spiral matrix fill block
package ssmf_pkg;
    localparam int unsigned VAL_W = 32;
    localparam int unsigned IDX_W = 3;
    localparam int unsigned DIM_W = 4;

    typedef enum logic [0:0] {
        REG_ROW_COUNT = 1'b0,
        REG_COL_COUNT = 1'b1
    } t_reg_idx;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SORT,
        ST_RANK,
        ST_WALK,
        ST_EMIT_RD,
        ST_EMIT
    } t_back_state;

    // one queue entry between front and back
    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic             last;
    } t_elem;
endpackage

FILE: rtl/core/sorted_spiral_matrix_fill.sv
// top level of the sorted spiral matrix fill block
// a run is ranked after its last transfer, then laid out on the spiral,
// then its cells emit in row-major order
// throughput: one input transfer per cycle while loading; the rank loop
// reads one stored element a cycle, which sets the run time
// reset: synchronous active low, dimensions return to 8, counts clear
module sorted_spiral_matrix_fill #(
    parameter int unsigned MAX_DIM = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_idx,
    input  logic [3:0]  i_cfg_data,
    input  logic        push,
    output logic        full,
    input  logic [31:0] i_elem_value,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] o_cell_value,
    output logic [2:0]  o_cell_row,
    output logic [2:0]  o_cell_col,
    output logic        o_run_last
);
    import ssmf_pkg::*;

    logic [DIM_W-1:0] r_rows, r_cols, w_rows, w_cols;
    logic  w_q_valid, w_q_pop;
    t_elem w_q_data;

    // dimension registers, written without handshake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= 4'd8;
            r_cols <= 4'd8;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_ROW_COUNT: r_rows <= i_cfg_data;
                REG_COL_COUNT: r_cols <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // clamp each dimension into 1..MAX_DIM
    assign w_rows = (r_rows == '0) ? 4'd1 :
                    (r_rows > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : r_rows;
    assign w_cols = (r_cols == '0) ? 4'd1 :
                    (r_cols > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : r_cols;

    ssmf_front #(.MAX_DIM(MAX_DIM)) u_front (
        .i_clk, .i_rst_n, .i_cfg_we, .i_rows(w_rows), .i_cols(w_cols),
        .i_push(push), .i_elem_value, .o_full(full),
        .o_q_valid(w_q_valid), .o_q_data(w_q_data), .i_q_pop(w_q_pop)
    );

    ssmf_back #(.MAX_DIM(MAX_DIM)) u_back (
        .i_clk, .i_rst_n, .i_cfg_we, .i_rows(w_rows), .i_cols(w_cols),
        .i_q_valid(w_q_valid), .i_q_data(w_q_data), .o_q_pop(w_q_pop),
        .o_empty(empty), .i_pop(pop), .o_cell_value, .o_cell_row,
        .o_cell_col, .o_run_last
    );
endmodule

FILE: rtl/core/ssmf_front.sv
// front part: counts loaded elements and marks the one that closes a run
module ssmf_front #(
    parameter int unsigned MAX_DIM = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [ssmf_pkg::DIM_W-1:0] i_rows,
    input  logic [ssmf_pkg::DIM_W-1:0] i_cols,
    input  logic                       i_push,
    input  logic [31:0]                i_elem_value,
    output logic                       o_full,
    output logic                       o_q_valid,
    output ssmf_pkg::t_elem            o_q_data,
    input  logic                       i_q_pop
);
    import ssmf_pkg::*;

    localparam int unsigned CNT_W = $clog2(MAX_DIM*MAX_DIM + 1);
    localparam int unsigned QD = 2;

    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] w_total;
    t_elem            r_q [QD];
    logic [1:0]       r_fill;
    logic             r_wp, r_rp;
    logic             w_acc, w_last;

    assign w_total = CNT_W'(i_rows) * CNT_W'(i_cols);
    assign o_full  = (r_fill == 2'(QD));
    assign w_acc   = i_push && !o_full;
    assign w_last  = (r_cnt + 1'b1) == w_total;
    assign o_q_valid = (r_fill != 2'd0);
    assign o_q_data  = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we) begin
            r_cnt <= '0;
        end else if (w_acc) begin
            r_cnt <= w_last ? '0 : r_cnt + 1'b1;
        end
        if (!i_rst_n) begin
            r_fill <= '0;
            r_wp   <= 1'b0;
            r_rp   <= 1'b0;
        end else begin
            if (w_acc) r_wp <= ~r_wp;
            if (i_q_pop && o_q_valid) r_rp <= ~r_rp;
            r_fill <= r_fill + 2'(w_acc) - 2'(i_q_pop && o_q_valid);
        end
        if (w_acc) begin
            r_q[r_wp].value <= i_elem_value;
            r_q[r_wp].last  <= w_last;
        end
    end
endmodule

FILE: rtl/core/ssmf_back.sv
// back part: stores a run, ranks it, emits the spiral-filled matrix
module ssmf_back #(
    parameter int unsigned MAX_DIM = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [ssmf_pkg::DIM_W-1:0] i_rows,
    input  logic [ssmf_pkg::DIM_W-1:0] i_cols,
    input  logic                       i_q_valid,
    input  ssmf_pkg::t_elem            i_q_data,
    output logic                       o_q_pop,
    output logic                       o_empty,
    input  logic                       i_pop,
    output logic [31:0]                o_cell_value,
    output logic [2:0]                 o_cell_row,
    output logic [2:0]                 o_cell_col,
    output logic                       o_run_last
);
    import ssmf_pkg::*;

    localparam int unsigned DEPTH = MAX_DIM*MAX_DIM;
    localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW    = $clog2(DEPTH + 1);

    t_back_state r_st, n_st;
    logic [31:0] r_val_mem [DEPTH];
    logic [31:0] r_srt_mem [DEPTH];     // values by sorted rank
    logic [31:0] r_out_mem [DEPTH];     // values laid out by cell address
    logic [CW-1:0] r_n, r_i, r_j, r_rank;
    logic [31:0] r_key, r_rd, r_srt_rd;
    logic [AW-1:0] r_cell;
    logic [2:0] r_er, r_ec;
    logic r_has;
    logic [CW-1:0] w_total;
    logic [AW-1:0] w_rank_fin;

    // spiral walker state
    logic [2:0] r_sr, r_sc, r_top, r_bot, r_lft, r_rgt;
    logic [1:0] r_dir;
    logic [2:0] n_sr, n_sc, n_top, n_bot, n_lft, n_rgt;
    logic [1:0] n_dir;
    logic       w_lt, w_eq_before;

    assign w_total = CW'(i_rows) * CW'(i_cols);
    assign o_q_pop = (r_st == ST_LOAD) && i_q_valid;
    assign o_empty = !r_has;

    // stable rank compare: r_rd is element j-1, key is element i
    assign w_lt        = $signed(r_rd) < $signed(r_key);
    assign w_eq_before = (r_rd == r_key) && ((r_j - 1'b1) < r_i);
    assign w_rank_fin  = r_rank[AW-1:0] + AW'(w_lt || w_eq_before);

    // spiral step: turn clockwise at each edge, shrinking bounds
    always_comb begin
        n_sr = r_sr; n_sc = r_sc; n_dir = r_dir;
        n_top = r_top; n_bot = r_bot; n_lft = r_lft; n_rgt = r_rgt;
        case (r_dir)
            2'd0: if (r_sc == r_rgt) begin
                n_top = r_top + 1'b1; n_dir = 2'd1; n_sr = r_sr + 1'b1;
            end else n_sc = r_sc + 1'b1;
            2'd1: if (r_sr == r_bot) begin
                n_rgt = r_rgt - 1'b1; n_dir = 2'd2; n_sc = r_sc - 1'b1;
            end else n_sr = r_sr + 1'b1;
            2'd2: if (r_sc == r_lft) begin
                n_bot = r_bot - 1'b1; n_dir = 2'd3; n_sr = r_sr - 1'b1;
            end else n_sc = r_sc - 1'b1;
            default: if (r_sr == r_top) begin
                n_lft = r_lft + 1'b1; n_dir = 2'd0; n_sc = r_sc + 1'b1;
            end else n_sr = r_sr - 1'b1;
        endcase
    end

    always_comb begin
        n_st = r_st;
        case (r_st)
            ST_LOAD:    if (i_q_valid && i_q_data.last) n_st = ST_SORT;
            ST_SORT:    n_st = ST_RANK;
            ST_RANK:    if (r_j == r_n) n_st = (r_i + 1'b1 == r_n) ? ST_WALK : ST_SORT;
            ST_WALK:    if (r_i == r_n) n_st = ST_EMIT_RD;
            ST_EMIT_RD: n_st = ST_EMIT;
            ST_EMIT:    if (i_pop) n_st = o_run_last ? ST_LOAD : ST_EMIT_RD;
            default:    n_st = ST_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= ST_LOAD;
            r_n   <= '0;
            r_has <= 1'b0;
        end else begin
            r_st <= n_st;
            if (i_cfg_we) r_n <= '0;
            case (r_st)
                ST_LOAD: if (o_q_pop) begin
                    r_n <= i_q_data.last ? w_total : r_n + 1'b1;
                    r_i <= '0;
                    // spiral walker starts at the top-left corner
                    r_sr <= '0; r_sc <= '0; r_dir <= 2'd0;
                    r_top <= '0; r_lft <= '0;
                    r_bot <= 3'(i_rows - 1'b1); r_rgt <= 3'(i_cols - 1'b1);
                end
                ST_SORT: begin
                    r_key  <= r_val_mem[r_i[AW-1:0]];
                    r_j    <= '0;
                    r_rank <= '0;
                end
                ST_RANK: begin
                    if (r_j != '0 && (w_lt || w_eq_before)) r_rank <= r_rank + 1'b1;
                    if (r_j == r_n) begin
                        r_i <= (r_i + 1'b1 == r_n) ? '0 : r_i + 1'b1;
                    end else begin
                        r_j <= r_j + 1'b1;
                    end
                end
                ST_WALK: begin
                    // walk one spiral cell per sorted value
                    r_cell <= AW'(r_sr * MAX_DIM + r_sc);
                    r_sr <= n_sr; r_sc <= n_sc; r_dir <= n_dir;
                    r_top <= n_top; r_bot <= n_bot; r_lft <= n_lft; r_rgt <= n_rgt;
                    r_j <= '0;
                    if (r_i != r_n) r_i <= r_i + 1'b1;
                end
                ST_EMIT_RD: begin
                    r_j   <= r_j + 1'b1;
                    r_has <= 1'b1;
                end
                ST_EMIT: begin
                    if (i_pop) begin
                        r_has <= 1'b0;
                        if (o_run_last) r_n <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    // memories and payload
    always_ff @(posedge i_clk) begin
        if (r_st == ST_LOAD && o_q_pop) r_val_mem[r_n[AW-1:0]] <= i_q_data.value;
        r_rd <= r_val_mem[r_j[AW-1:0]];
        if (r_st == ST_RANK && r_j == r_n) r_srt_mem[w_rank_fin] <= r_key;
        r_srt_rd <= r_srt_mem[r_i[AW-1:0]];
        // the registered sorted value lands on the registered cell of the same walk step
        if (r_st == ST_WALK && r_i != '0) r_out_mem[r_cell] <= r_srt_rd;
        if (r_st == ST_WALK) begin
            r_er <= '0; r_ec <= '0;
        end
        if (r_st == ST_EMIT_RD) begin
            o_cell_value <= r_out_mem[AW'(r_er * MAX_DIM + r_ec)];
            o_cell_row   <= r_er;
            o_cell_col   <= r_ec;
            o_run_last   <= (r_j == r_n - 1'b1);
            if (4'(r_ec) + 1'b1 == i_cols) begin
                r_ec <= '0; r_er <= r_er + 1'b1;
            end else r_ec <= r_ec + 1'b1;
        end
    end
endmodule

FILE: rtl/core/ssmf_checker.sv
// port-level checks for the sorted spiral matrix fill block
module ssmf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        empty,
    input logic        pop,
    input logic [2:0]  o_cell_row,
    input logic [2:0]  o_cell_col,
    input logic        o_run_last
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_cell_row) && $stable(o_cell_col))
        else $error("result changed while stalled");
    a_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && pop && o_run_last |=> empty || (o_cell_row == 3'd0 && o_cell_col == 3'd0))
        else $error("run did not restart at origin");
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result after reset");
endmodule

bind sorted_spiral_matrix_fill ssmf_checker u_chk (.*);

FILE: tb/spiral_cell_checker.sv
// checker that predicts and compares the cells of the sorted spiral matrix fill block
`timescale 1ns / 1ps
module spiral_cell_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_idx,
    input  logic [3:0]  i_cfg_data,
    input  logic        push,
    input  logic        full,
    input  logic [31:0] i_elem_value,
    input  logic        empty,
    input  logic        pop,
    input  logic [31:0] i_cell_value,
    input  logic [2:0]  i_cell_row,
    input  logic [2:0]  i_cell_col,
    input  logic        i_run_last,
    output int          o_fail_count,
    output int          o_cells_pending
);
    import ssmf_pkg::*;

    typedef struct {
        logic [31:0] value;
        logic [2:0]  row;
        logic [2:0]  col;
        logic        last;
    } t_cell;

    t_cell       cell_expect_q[$];
    t_cell       cell_exp;
    logic [31:0] elem_store [0:63];
    int unsigned load_cnt;
    logic [3:0]  row_reg;
    logic [3:0]  col_reg;

    initial begin
        o_fail_count    = 0;
        o_cells_pending = 0;
        load_cnt        = 0;
        row_reg         = 4'd8;
        col_reg         = 4'd8;
    end

    function automatic int unsigned dim_in_use(logic [3:0] v);
        if (v == 4'd0) return 1;
        if (v > 4'd8) return 8;
        return v;
    endfunction

    // sort the run, lay it out clockwise from the top-left, queue it row by row
    task automatic predict_spiral_matrix();
        int                 rows, cols, total;
        int                 top, bot, lft, rgt, k, i, j;
        logic signed [31:0] sorted [64];
        logic signed [31:0] key;
        logic [31:0]        grid [8][8];
        t_cell              c;
        rows  = dim_in_use(row_reg);
        cols  = dim_in_use(col_reg);
        total = rows * cols;
        for (i = 0; i < total; i++) sorted[i] = elem_store[i];
        for (i = 1; i < total; i++) begin
            key = sorted[i];
            j   = i;
            while (j > 0 && key < sorted[j-1]) begin
                sorted[j] = sorted[j-1];
                j--;
            end
            sorted[j] = key;
        end
        top = 0; bot = rows - 1; lft = 0; rgt = cols - 1; k = 0;
        while (top <= bot && lft <= rgt) begin
            for (i = lft; i <= rgt; i++) grid[top][i] = sorted[k++];
            top++;
            for (i = top; i <= bot; i++) grid[i][rgt] = sorted[k++];
            rgt--;
            if (top <= bot) begin
                for (i = rgt; i >= lft; i--) grid[bot][i] = sorted[k++];
                bot--;
            end
            if (lft <= rgt) begin
                for (i = bot; i >= top; i--) grid[i][lft] = sorted[k++];
                lft++;
            end
        end
        k = 0;
        for (i = 0; i < rows; i++) begin
            for (j = 0; j < cols; j++) begin
                c.value = grid[i][j];
                c.row   = i[2:0];
                c.col   = j[2:0];
                c.last  = (k + 1 == total);
                cell_expect_q.push_back(c);
                k++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            row_reg  = 4'd8;
            col_reg  = 4'd8;
            load_cnt = 0;
            cell_expect_q.delete();
        end else begin
            // any register write drops a partial run
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_ROW_COUNT) row_reg = i_cfg_data;
                else col_reg = i_cfg_data;
                load_cnt = 0;
            end
            if (push && !full) begin
                if (load_cnt < 64) elem_store[load_cnt] = i_elem_value;
                load_cnt = (load_cnt + 1) & 7'h7f;
                if (load_cnt >= dim_in_use(row_reg) * dim_in_use(col_reg)) begin
                    predict_spiral_matrix();
                    load_cnt = 0;
                end
            end
            if (pop && !empty) begin
                if (cell_expect_q.size() == 0) begin
                    $display("%0t unexpected cell transfer: value %h row %0d col %0d last %0b",
                             $time, i_cell_value, i_cell_row, i_cell_col, i_run_last);
                    o_fail_count++;
                end else begin
                    cell_exp = cell_expect_q.pop_front();
                    if (cell_exp.value !== i_cell_value || cell_exp.row !== i_cell_row ||
                        cell_exp.col !== i_cell_col || cell_exp.last !== i_run_last) begin
                        $display("%0t cell mismatch: expected value %h row %0d col %0d last %0b",
                                 $time, cell_exp.value, cell_exp.row, cell_exp.col,
                                 cell_exp.last);
                        $display("%0t                actual value %h row %0d col %0d last %0b",
                                 $time, i_cell_value, i_cell_row, i_cell_col, i_run_last);
                        o_fail_count++;
                    end
                end
            end
        end
        o_cells_pending = cell_expect_q.size();
    end
endmodule

FILE: tb/sorted_spiral_matrix_fill_tb.sv
// top of the testbench: stimulus, receiver pacing and verdict
`timescale 1ns / 1ps
module sorted_spiral_matrix_fill_tb;
    import ssmf_pkg::*;

    localparam int CYCLE_LIMIT = 600000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [0:0]  i_cfg_idx = REG_ROW_COUNT;
    logic [3:0]  i_cfg_data = 4'd0;
    logic        push = 1'b0;
    logic        full;
    logic [31:0] i_elem_value = 32'd0;
    logic        empty;
    logic        pop = 1'b0;
    logic [31:0] o_cell_value;
    logic [2:0]  o_cell_row;
    logic [2:0]  o_cell_col;
    logic        o_run_last;

    int fail_count;
    int cells_pending;
    int elems_sent = 0;
    int cycle_cnt = 0;
    bit long_hold_req = 1'b0;

    sorted_spiral_matrix_fill #(.MAX_DIM(8)) u_dut (.*);

    spiral_cell_checker u_checker (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .push, .full, .i_elem_value, .empty, .pop,
        .i_cell_value    (o_cell_value),
        .i_cell_row      (o_cell_row),
        .i_cell_col      (o_cell_col),
        .i_run_last      (o_run_last),
        .o_fail_count    (fail_count),
        .o_cells_pending (cells_pending)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // mostly back to back, sometimes a short gap, rarely a long gap
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // small sizes most of the time, zero and out of range now and then
    function automatic logic [3:0] pick_dim();
        int r;
        r = $urandom_range(0, 19);
        if (r < 13) return 4'($urandom_range(1, 4));
        if (r < 17) return 4'($urandom_range(5, 8));
        if (r < 18) return 4'd0;
        return 4'($urandom_range(9, 15));
    endfunction

    // full range, a tight cluster for duplicates, or the extremes
    function automatic logic [31:0] pick_elem();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5) return $urandom;
        if (r < 8) return $urandom_range(0, 6) - 3;
        if (r < 9) return 32'h8000_0000 + $urandom_range(0, 2);
        return 32'h7fff_ffff - $urandom_range(0, 2);
    endfunction

    function automatic int dim_used(logic [3:0] v);
        return (v == 0) ? 1 : (v > 8) ? 8 : v;
    endfunction

    // receiver: random pops, a rare long stall, one very long hold-off on request
    initial begin : receiver
        int hold_cnt;
        hold_cnt = 0;
        forever begin
            @(posedge i_clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold_cnt = 6000;
            end
            if (hold_cnt == 0 && $urandom_range(0, 99) == 0)
                hold_cnt = $urandom_range(20, 60);
            if (hold_cnt > 0) begin
                pop <= 1'b0;
                hold_cnt--;
            end else begin
                pop <= ($urandom_range(0, 9) < 7);
            end
        end
    end

    initial begin : watchdog
        forever begin
            @(posedge i_clk);
            cycle_cnt++;
            if (cycle_cnt > CYCLE_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    // one element transfer, then an optional gap with push low
    task automatic send_elem(logic [31:0] v);
        int gap;
        push         <= 1'b1;
        i_elem_value <= v;
        do @(posedge i_clk); while (full);
        elems_sent++;
        gap = gap_len();
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // sender waits until every expected cell has come back
    task automatic drain_cells();
        @(negedge i_clk);
        while (cells_pending != 0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    // dimensions change only with the block idle
    task automatic set_dims(logic [3:0] rows, logic [3:0] cols);
        push <= 1'b0;
        drain_cells();
        repeat (20) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_ROW_COUNT;
        i_cfg_data <= rows;
        @(posedge i_clk);
        i_cfg_idx  <= REG_COL_COUNT;
        i_cfg_data <= cols;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    initial begin : stimulus
        logic [3:0] rows, cols;
        int         run_len, n_runs, n_send;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // single cell runs at the value extremes
        set_dims(4'd1, 4'd1);
        send_elem(32'h8000_0000);
        send_elem(32'h7fff_ffff);
        send_elem(32'h0000_0000);
        send_elem(32'hffff_ffff);
        // zero rows read as one, fifteen columns read as eight; duplicates inside
        set_dims(4'd0, 4'd15);
        send_elem(32'h7fff_ffff);
        send_elem(32'h8000_0000);
        send_elem(32'd5);
        send_elem(32'd5);
        send_elem(32'hffff_ffff);
        send_elem(32'd0);
        send_elem(32'd1);
        send_elem(32'h8000_0000);
        // partial run thrown away by a register write
        set_dims(4'd3, 4'd3);
        repeat (4) send_elem(pick_elem());
        set_dims(4'd2, 4'd3);
        repeat (6) send_elem(pick_elem());

        // full size runs with the receiver held off so the input backs up
        set_dims(4'd8, 4'd8);
        long_hold_req = 1'b1;
        repeat (128) send_elem(pick_elem());

        while (elems_sent < 410) begin
            rows = pick_dim();
            cols = pick_dim();
            set_dims(rows, cols);
            run_len = dim_used(rows) * dim_used(cols);
            n_runs  = (run_len > 20) ? 1 : $urandom_range(1, 3);
            n_send  = n_runs * run_len;
            // now and then leave a partial run for the next write to discard
            if (run_len > 1 && $urandom_range(0, 7) == 0)
                n_send += $urandom_range(1, run_len - 1);
            repeat (n_send) send_elem(pick_elem());
        end

        // close out with a clean run so nothing is left half loaded
        set_dims(4'd2, 4'd2);
        repeat (4) send_elem(pick_elem());
        push <= 1'b0;
        drain_cells();
        repeat (200) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
